// ----- rtl/core/pnm_binary_header_parser_core_macros.svh -----
// ----------------------------------------------------------------------------
// PNM header parser assertion macros
// Short forms for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef PNM_BINARY_HEADER_PARSER_CORE_MACROS_SVH
`define PNM_BINARY_HEADER_PARSER_CORE_MACROS_SVH

// same-cycle implication
`define PBHP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PBHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/pbhp_pkg.sv -----
// ----------------------------------------------------------------------------
// PNM header parser package
// Character codes, status and magic codes, limits and the result record.
// ----------------------------------------------------------------------------
package pbhp_pkg;

  localparam int unsigned WINDOW_MAX_DEF = 1024;

  // character codes
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam int unsigned MIN_WINDOW  = 10;
  localparam int unsigned WIDE_THRESH = 256;

  // saturation value and row-size limits per bytes-per-pixel (1, 2, 3, 6)
  localparam logic [30:0] SAT_MAX = 31'h7FFF_FFFF;
  localparam logic [30:0] LIM_BPP2 = 31'(32'h7FFF_FFFF / 2);
  localparam logic [30:0] LIM_BPP3 = 31'(32'h7FFF_FFFF / 3);
  localparam logic [30:0] LIM_BPP6 = 31'(32'h7FFF_FFFF / 6);

  typedef enum logic [1:0] {
    MAGIC_NONE    = 2'd0,
    MAGIC_GRAY    = 2'd1,
    MAGIC_RGB     = 2'd2,
    MAGIC_PENDING = 2'd3
  } magic_t;

  typedef enum logic [1:0] {
    PH_SIGN   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MAGIC    = 2'd1,
    ST_VALUE    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    status_t            status;
    logic               is_color;
    logic signed [31:0] width;
    logic signed [31:0] height;
    logic signed [31:0] max_value;
    logic               wide_samples;
    logic [10:0]        data_offset;
    logic [30:0]        row_bytes;
  } res_t;

endpackage

// ----- rtl/core/pnm_binary_header_parser_core.sv -----
// ----------------------------------------------------------------------------
// PNM binary header parser core
// Parses a P5/P6 netpbm header window byte by byte and reports one result
// record (status, kind, dimensions, maxval, data offset, row size) per window.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                            | tuser          | tlast
//  --------+-----+----------------------------------+----------------+-----------
//  in_     | in  | [7:0] hdr_byte                   | -              | window_end
//  out_    | out | status, width, height, max_value,| is_color,      | -
//          |     | data_offset, row_bytes           | wide_samples   |
//
//  One header byte is taken per cycle unless in_tready is low; the byte parser is a
//  single state update per beat (compare, then a times-ten accumulate).
//  A result passes the input register, the end-of-window snapshot register and
//  the output register after its window_end beat.
//  rst_n (synchronous, active low) clears all control state and the parser.
//  Back-pressure on out_ only stalls the input once a second window end would
//  overwrite an undelivered snapshot; ordinary bytes keep flowing.
// ----------------------------------------------------------------------------
`include "pnm_binary_header_parser_core_macros.svh"

module pnm_binary_header_parser_core
  import pbhp_pkg::*;
#(
  parameter int unsigned WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // input beats
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] hdr_byte
  input  logic         in_tlast,   // window_end
  // result beats
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // [1:0] status, [33:2] width, [65:34] height,
                                   // [97:66] max_value, [108:98] data_offset,
                                   // [139:109] row_bytes, [143:140] zero
  output logic [1:0]   out_tuser   // [0] is_color, [1] wide_samples
);

  // byte counter holds 0..WINDOW_MAX
  localparam int unsigned CW = $clog2(WINDOW_MAX + 1);

  // ---------------------------------------------------------------- input reg
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_fin_r;

  // ------------------------------------------------------------ parser state
  logic [CW-1:0]      cnt_r, cnt_nxt;
  magic_t             magic_r, magic_nxt;
  logic               in_comment_r, in_comment_nxt;
  logic [1:0]         tok_num_r, tok_num_nxt;
  logic               started_r, started_nxt;
  phase_t             phase_r, phase_nxt;
  logic               neg_r, neg_nxt;
  logic [30:0]        acc_r, acc_nxt;
  logic signed [31:0] val_r [3];
  logic signed [31:0] val_nxt [3];
  logic [CW-1:0]      offset_r, offset_nxt;

  // per-beat step results (before the end-of-window clear)
  logic [CW-1:0]      s_cnt;
  magic_t             s_magic;
  logic               s_in_comment;
  logic [1:0]         s_tok_num;
  logic               s_started;
  phase_t             s_phase;
  logic               s_neg;
  logic [30:0]        s_acc;
  logic signed [31:0] s_val [3];
  logic [CW-1:0]      s_offset;

  // ---------------------------------------------------------- snapshot stage
  logic               snap_vld_r;
  logic               snap_short_r;
  magic_t             snap_magic_r;
  logic               snap_tok3_r;
  logic signed [31:0] snap_w_r, snap_h_r, snap_m_r;
  logic [10:0]        snap_off_r;

  // ------------------------------------------------------------ output stage
  logic out_vld_r;
  res_t out_res_r;
  res_t res_nxt;

  // flow control
  logic snap_take;
  logic adv_a;

  assign snap_take = snap_vld_r && (!out_vld_r || out_tready);
  // a window end needs a free snapshot slot; other bytes always advance
  assign adv_a     = in_vld_r && (!in_fin_r || !snap_vld_r || snap_take);
  assign in_tready = !in_vld_r || adv_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_fin_r  <= in_tlast;
    end
  end

  // ---------------------------------------------------------- byte step logic
  logic          b_ws;
  logic          b_magic_ws;
  logic          b_digit;
  logic          b_sign;
  logic          active;
  logic          parse_en;
  logic          do_exam;
  logic [34:0]   prod;
  logic [31:0]   mag;

  always_comb begin
    b_ws       = (in_byte_r == CH_SPACE) ||
                 (in_byte_r >= CH_TAB && in_byte_r <= CH_CR);
    b_magic_ws = (in_byte_r == CH_SPACE) || (in_byte_r == CH_TAB) ||
                 (in_byte_r == CH_LF) || (in_byte_r == CH_CR);
    b_digit    = (in_byte_r >= CH_ZERO) && (in_byte_r <= CH_NINE);
    b_sign     = (in_byte_r == CH_PLUS) || (in_byte_r == CH_MINUS);
    active     = cnt_r < CW'(WINDOW_MAX);
    parse_en   = active && (cnt_r >= CW'(2)) && (tok_num_r != 2'd3);
    // times ten plus digit; digit value is the low nibble of '0'..'9'
    prod       = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} +
                 {31'd0, in_byte_r[3:0]};
    mag        = {1'b0, acc_r};

    s_cnt        = cnt_r;
    s_magic      = magic_r;
    s_in_comment = in_comment_r;
    s_tok_num    = tok_num_r;
    s_started    = started_r;
    s_phase      = phase_r;
    s_neg        = neg_r;
    s_acc        = acc_r;
    s_val        = val_r;
    s_offset     = offset_r;
    do_exam      = 1'b0;

    if (active) begin
      s_cnt = cnt_r + CW'(1);
      if (cnt_r == CW'(0)) begin
        s_magic = (in_byte_r == CH_P) ? MAGIC_PENDING : MAGIC_NONE;
      end else if (cnt_r == CW'(1)) begin
        if (magic_r == MAGIC_PENDING && in_byte_r == CH_5) begin
          s_magic = MAGIC_GRAY;
        end else if (magic_r == MAGIC_PENDING && in_byte_r == CH_6) begin
          s_magic = MAGIC_RGB;
        end else begin
          s_magic = MAGIC_NONE;
        end
      end else if (cnt_r == CW'(2)) begin
        if (!b_magic_ws) begin
          s_magic = MAGIC_NONE;
        end
      end
    end

    // comment skipping; the final byte is always examined
    if (parse_en) begin
      if (in_comment_r) begin
        if (in_byte_r == CH_LF || in_byte_r == CH_CR) begin
          s_in_comment = 1'b0;
          do_exam      = 1'b1;
        end else if (in_fin_r) begin
          do_exam = 1'b1;
        end
      end else if (in_byte_r == CH_HASH && !in_fin_r) begin
        s_in_comment = 1'b1;
      end else begin
        do_exam = 1'b1;
      end
    end

    if (do_exam) begin
      if (b_ws) begin
        if (started_r) begin
          case (tok_num_r)
            2'd0:    s_val[0] = neg_r ? -mag : mag;
            2'd1:    s_val[1] = neg_r ? -mag : mag;
            default: s_val[2] = neg_r ? -mag : mag;
          endcase
          s_tok_num = tok_num_r + 2'd1;
          if (tok_num_r == 2'd2) begin
            s_offset = cnt_r + CW'(1);
          end
          s_started = 1'b0;
          s_phase   = PH_SIGN;
          s_neg     = 1'b0;
          s_acc     = '0;
        end
      end else begin
        s_started = 1'b1;
        case (phase_r)
          PH_SIGN: begin
            if (b_sign) begin
              s_neg   = (in_byte_r == CH_MINUS);
              s_phase = PH_DIGITS;
            end else if (b_digit) begin
              s_phase = PH_DIGITS;
              s_acc   = prod[30:0];
            end else begin
              s_phase = PH_DONE;
            end
          end
          PH_DIGITS: begin
            if (b_digit) begin
              s_acc = (prod > {4'd0, SAT_MAX}) ? SAT_MAX : prod[30:0];
            end else begin
              s_phase = PH_DONE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // the window end clears the parser for the next window
  always_comb begin
    cnt_nxt        = cnt_r;
    magic_nxt      = magic_r;
    in_comment_nxt = in_comment_r;
    tok_num_nxt    = tok_num_r;
    started_nxt    = started_r;
    phase_nxt      = phase_r;
    neg_nxt        = neg_r;
    acc_nxt        = acc_r;
    val_nxt        = val_r;
    offset_nxt     = offset_r;
    if (adv_a) begin
      if (in_fin_r) begin
        cnt_nxt        = '0;
        magic_nxt      = MAGIC_NONE;
        in_comment_nxt = 1'b0;
        tok_num_nxt    = 2'd0;
        started_nxt    = 1'b0;
        phase_nxt      = PH_SIGN;
        neg_nxt        = 1'b0;
        acc_nxt        = '0;
        val_nxt[0]     = -32'sd1;
        val_nxt[1]     = -32'sd1;
        val_nxt[2]     = -32'sd1;
        offset_nxt     = CW'(2);
      end else begin
        cnt_nxt        = s_cnt;
        magic_nxt      = s_magic;
        in_comment_nxt = s_in_comment;
        tok_num_nxt    = s_tok_num;
        started_nxt    = s_started;
        phase_nxt      = s_phase;
        neg_nxt        = s_neg;
        acc_nxt        = s_acc;
        val_nxt        = s_val;
        offset_nxt     = s_offset;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      magic_r      <= MAGIC_NONE;
      in_comment_r <= 1'b0;
      tok_num_r    <= 2'd0;
      started_r    <= 1'b0;
      phase_r      <= PH_SIGN;
      neg_r        <= 1'b0;
      acc_r        <= '0;
      val_r[0]     <= -32'sd1;
      val_r[1]     <= -32'sd1;
      val_r[2]     <= -32'sd1;
      offset_r     <= CW'(2);
    end else begin
      cnt_r        <= cnt_nxt;
      magic_r      <= magic_nxt;
      in_comment_r <= in_comment_nxt;
      tok_num_r    <= tok_num_nxt;
      started_r    <= started_nxt;
      phase_r      <= phase_nxt;
      neg_r        <= neg_nxt;
      acc_r        <= acc_nxt;
      val_r        <= val_nxt;
      offset_r     <= offset_nxt;
    end
  end

  // ------------------------------------------------------- end-of-window snap
  logic [CW+10:0] off_ext;
  assign off_ext = {11'd0, s_offset};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_vld_r <= 1'b0;
    end else if (adv_a && in_fin_r) begin
      snap_vld_r <= 1'b1;
    end else if (snap_take) begin
      snap_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a && in_fin_r) begin
      snap_short_r <= s_cnt < CW'(MIN_WINDOW);
      snap_magic_r <= s_magic;
      snap_tok3_r  <= s_tok_num == 2'd3;
      snap_w_r     <= s_val[0];
      snap_h_r     <= s_val[1];
      snap_m_r     <= s_val[2];
      snap_off_r   <= off_ext[10:0];
    end
  end

  // --------------------------------------------------------- result decoding
  logic        r_color;
  logic        r_wide;
  logic        r_magic_ok;
  logic        r_val_bad;
  logic [30:0] r_lim;
  logic [30:0] r_w3;

  always_comb begin
    r_color    = snap_magic_r == MAGIC_RGB;
    r_magic_ok = (snap_magic_r == MAGIC_GRAY) || (snap_magic_r == MAGIC_RGB);
    r_wide     = !snap_m_r[31] && (snap_m_r[30:0] >= 31'(WIDE_THRESH));
    r_val_bad  = !snap_tok3_r ||
                 snap_w_r[31] || (snap_w_r == 32'sd0) ||
                 snap_h_r[31] || (snap_h_r == 32'sd0) ||
                 snap_m_r[31] || (snap_m_r == 32'sd0);
    case ({r_color, r_wide})
      2'b00:   r_lim = SAT_MAX;
      2'b01:   r_lim = LIM_BPP2;
      2'b10:   r_lim = LIM_BPP3;
      default: r_lim = LIM_BPP6;
    endcase
    // times three by shift-add; only used when it cannot overflow
    r_w3 = r_color ? ({snap_w_r[29:0], 1'b0} + snap_w_r[30:0]) : snap_w_r[30:0];

    res_nxt.is_color     = r_color;
    res_nxt.width        = snap_w_r;
    res_nxt.height       = snap_h_r;
    res_nxt.max_value    = snap_m_r;
    res_nxt.wide_samples = r_wide;
    res_nxt.data_offset  = snap_off_r;
    res_nxt.row_bytes    = '0;
    if (snap_short_r || !r_magic_ok) begin
      res_nxt.status = ST_MAGIC;
    end else if (r_val_bad) begin
      res_nxt.status = ST_VALUE;
    end else if (snap_w_r[30:0] > r_lim) begin
      res_nxt.status = ST_OVERFLOW;
    end else begin
      res_nxt.status    = ST_OK;
      res_nxt.row_bytes = r_wide ? {r_w3[29:0], 1'b0} : r_w3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (snap_take) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'd0,
                       out_res_r.row_bytes,
                       out_res_r.data_offset,
                       out_res_r.max_value,
                       out_res_r.height,
                       out_res_r.width,
                       out_res_r.status};
  assign out_tuser  = {out_res_r.wide_samples, out_res_r.is_color};

  // --------------------------------------------------------------- assertions
  `PBHP_ASSERT_NEXT(a_fin_loads_snap, adv_a && in_fin_r, snap_vld_r, "window end lost before snapshot")
  `PBHP_ASSERT_NEXT(a_fin_clears, adv_a && in_fin_r, cnt_r == '0 && tok_num_r == 2'd0 && !in_comment_r, "parser not cleared after window end")
  `PBHP_ASSERT_NOW(a_offset_idle, tok_num_r != 2'd3, offset_r == CW'(2), "data offset moved before third token")
  `PBHP_ASSERT_NOW(a_comment_pos, in_comment_r, cnt_r > CW'(2), "comment open inside magic bytes")
  `PBHP_ASSERT_NOW(a_ok_row, out_vld_r && out_res_r.status == ST_OK, out_res_r.row_bytes != '0, "ok status with zero row size")

endmodule
